@@ rtl/md5_stream_hasher_macros.svh @@
// ---------------------------------------------------------------------------
// md5_stream_hasher assertion macros
// Shared concurrent assertion forms, sampled on clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef MD5_STREAM_HASHER_MACROS_SVH
`define MD5_STREAM_HASHER_MACROS_SVH

// Same-cycle implication.
`define MD5SH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("md5 stream hasher: check failed");

// Next-cycle implication.
`define MD5SH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("md5 stream hasher: check failed");

`endif

@@ rtl/md5sh_pkg.sv @@
// ---------------------------------------------------------------------------
// md5sh_pkg
// Types, constants and helper functions shared by the MD5 stream hasher.
// ---------------------------------------------------------------------------
package md5sh_pkg;

    localparam int WORD_W     = 32;
    localparam int NUM_BANKS  = 2;
    localparam int BANK_WORDS = 16;
    localparam int RAM_DEPTH  = NUM_BANKS * BANK_WORDS;
    localparam int RAM_AW     = $clog2(RAM_DEPTH);
    localparam int DESC_DEPTH = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       final_req;
    } byte_item_t;

    typedef struct packed {
        logic [63:0] digest_half;
        logic        half_index;
        logic        last_half;
    } digest_item_t;

    // Block descriptor handed from the front end to the round engine.
    typedef struct packed {
        logic last;
        logic bank;
    } desc_t;

    typedef enum logic [1:0] {
        FR_ABSORB,
        FR_PAD,
        FR_LEN
    } front_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ROUND,
        BK_FOLD
    } back_state_t;

    localparam logic [3:0][31:0] MD5_IV = {
        32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    localparam logic [0:63][31:0] ROUND_K = {
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Indexed by {phase, round[1:0]}.
    localparam logic [0:15][4:0] ROT_AMT = {
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] t;
        t = {v, v} << s;
        return t[63:32];
    endfunction

    // Message word used by a given round.
    function automatic logic [3:0] msg_idx(input logic [5:0] r);
        logic [3:0] n;
        n = r[3:0];
        unique case (r[5:4])
            2'd0: return n;
            2'd1: return n + (n << 2) + 4'd1;
            2'd2: return n + (n << 1) + 4'd5;
            2'd3: return (n << 3) - n;
        endcase
    endfunction

endpackage

@@ rtl/md5sh_ram.sv @@
// ---------------------------------------------------------------------------
// md5sh_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module md5sh_ram #(
    parameter int WIDTH = md5sh_pkg::WORD_W,
    parameter int DEPTH = md5sh_pkg::RAM_DEPTH
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/md5sh_front.sv @@
// ---------------------------------------------------------------------------
// md5sh_front
// Takes message bytes, packs them into words in the block RAM, appends
// padding and bit length on the final marker, and queues full blocks.
// ---------------------------------------------------------------------------
module md5sh_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  md5sh_pkg::byte_item_t     byte_item,
    input  logic                      blk_done,
    output logic                      desc_push,
    output md5sh_pkg::desc_t          desc,
    output logic                      ram_we,
    output logic [md5sh_pkg::RAM_AW-1:0] ram_waddr,
    output logic [md5sh_pkg::WORD_W-1:0] ram_wdata
);
    import md5sh_pkg::*;

    front_state_t state_reg, state_next;
    logic [63:0]  count_reg, count_next;
    logic [63:0]  len_reg, len_next;
    logic [5:0]   fill_reg, fill_next;
    logic [23:0]  word_reg, word_next;
    logic         pad_first_reg, pad_first_next;
    logic         bank_reg, bank_next;
    logic [1:0]   outs_reg, outs_next;

    logic       accept;
    logic       bank_free;
    logic       emit;
    logic [7:0] emit_byte;

    assign bank_free = (outs_reg != 2'(NUM_BANKS));
    assign accept    = push && !full;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FR_ABSORB:
            begin
                if (accept && byte_item.final_req)
                begin
                    state_next = FR_PAD;
                end
            end
            FR_PAD:
            begin
                if (emit && fill_reg == 6'd55)
                begin
                    state_next = FR_LEN;
                end
            end
            FR_LEN:
            begin
                if (emit && (&fill_reg))
                begin
                    state_next = FR_ABSORB;
                end
            end
            default: state_next = FR_ABSORB;
        endcase
    end

    // Outputs
    always_comb
    begin
        full      = (state_reg != FR_ABSORB) || !bank_free;
        emit      = 1'b0;
        emit_byte = 8'h00;
        unique case (state_reg)
            FR_ABSORB:
            begin
                emit      = accept && byte_item.byte_present;
                emit_byte = byte_item.data_byte;
            end
            FR_PAD:
            begin
                emit      = bank_free;
                emit_byte = pad_first_reg ? 8'h80 : 8'h00;
            end
            FR_LEN:
            begin
                emit      = bank_free;
                emit_byte = len_reg[{fill_reg[2:0], 3'b000} +: 8];
            end
            default:
            begin
                emit      = 1'b0;
                emit_byte = 8'h00;
            end
        endcase
        ram_we     = emit && (fill_reg[1:0] == 2'b11);
        ram_waddr  = {bank_reg, fill_reg[5:2]};
        ram_wdata  = {emit_byte, word_reg};
        desc_push  = emit && (&fill_reg);
        desc.bank  = bank_reg;
        desc.last  = (state_reg == FR_LEN);
    end

    // Datapath
    always_comb
    begin
        count_next     = count_reg;
        len_next       = len_reg;
        pad_first_next = pad_first_reg;
        word_next      = word_reg;
        fill_next      = emit ? fill_reg + 6'd1 : fill_reg;
        bank_next      = desc_push ? !bank_reg : bank_reg;
        outs_next      = outs_reg + {1'b0, desc_push} - {1'b0, blk_done};

        if (accept)
        begin
            if (byte_item.final_req)
            begin
                // latch the bit length including this transaction's byte
                len_next       = (count_reg + {63'd0, byte_item.byte_present}) << 3;
                count_next     = 64'd0;
                pad_first_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + {63'd0, byte_item.byte_present};
            end
        end
        if (state_reg == FR_PAD && emit)
        begin
            pad_first_next = 1'b0;
        end

        if (emit)
        begin
            unique case (fill_reg[1:0])
                2'd0: word_next[7:0]   = emit_byte;
                2'd1: word_next[15:8]  = emit_byte;
                2'd2: word_next[23:16] = emit_byte;
                2'd3: word_next        = word_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FR_ABSORB;
            count_reg     <= 64'd0;
            fill_reg      <= 6'd0;
            pad_first_reg <= 1'b0;
            bank_reg      <= 1'b0;
            outs_reg      <= 2'd0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            fill_reg      <= fill_next;
            pad_first_reg <= pad_first_next;
            bank_reg      <= bank_next;
            outs_reg      <= outs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg  <= len_next;
        word_reg <= word_next;
    end

endmodule

@@ rtl/md5sh_descq.sv @@
// ---------------------------------------------------------------------------
// md5sh_descq
// Two-entry queue of block descriptors between front end and round engine.
// ---------------------------------------------------------------------------
module md5sh_descq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  md5sh_pkg::desc_t  wr_desc,
    input  logic              rd,
    output md5sh_pkg::desc_t  rd_desc,
    output logic              q_empty
);
    import md5sh_pkg::*;

    localparam int PTR_W = $clog2(DESC_DEPTH);
    localparam int CNT_W = $clog2(DESC_DEPTH + 1);

    desc_t             entry_reg [DESC_DEPTH];
    logic [PTR_W-1:0]  wptr_reg, wptr_next;
    logic [PTR_W-1:0]  rptr_reg, rptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    assign q_empty = (cnt_reg == '0);
    assign rd_desc = entry_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wr ? PTR_W'(wptr_reg + 1'b1) : wptr_reg;
        rptr_next = rd ? PTR_W'(rptr_reg + 1'b1) : rptr_reg;
        cnt_next  = cnt_reg + CNT_W'(wr) - CNT_W'(rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            entry_reg[wptr_reg] <= wr_desc;
        end
    end

endmodule

@@ rtl/md5sh_back.sv @@
// ---------------------------------------------------------------------------
// md5sh_back
// Round engine: one MD5 round per cycle over a queued block, chaining value
// update, and a two-transaction digest output register.
// ---------------------------------------------------------------------------
module md5sh_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  md5sh_pkg::desc_t             q_desc,
    output logic                         q_pop,
    output logic [md5sh_pkg::RAM_AW-1:0] ram_raddr,
    input  logic [md5sh_pkg::WORD_W-1:0] ram_rdata,
    output logic                         blk_done,
    output logic                         empty,
    input  logic                         pop,
    output md5sh_pkg::digest_item_t      digest_item
);
    import md5sh_pkg::*;

    back_state_t      state_reg, state_next;
    logic [5:0]       round_reg, round_next;
    logic             bank_reg, bank_next;
    logic             last_reg, last_next;
    logic [31:0]      a_reg, b_reg, c_reg, d_reg;
    logic [31:0]      a_next, b_next, c_next, d_next;
    logic [3:0][31:0] cv_reg, cv_next;
    logic [3:0][31:0] digest_reg, digest_next;
    logic             out_valid_reg, out_valid_next;
    logic             half_reg, half_next;

    logic [31:0]      f;
    logic [31:0]      sum;
    logic [31:0]      b_round;
    logic [3:0][31:0] folded;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:  if (q_pop) state_next = BK_ROUND;
            BK_ROUND: if (&round_reg) state_next = BK_FOLD;
            BK_FOLD:  state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        // hold off a new block while a digest waits to be taken
        q_pop    = (state_reg == BK_IDLE) && !q_empty && !out_valid_reg;
        blk_done = (state_reg == BK_FOLD);
        if (state_reg == BK_IDLE)
        begin
            ram_raddr = {q_desc.bank, 4'd0};
        end
        else
        begin
            // fetch one round ahead to cover the RAM read latency
            ram_raddr = {bank_reg, msg_idx(round_reg + 6'd1)};
        end
        empty                   = !out_valid_reg;
        digest_item.digest_half = half_reg ? {digest_reg[3], digest_reg[2]}
                                           : {digest_reg[1], digest_reg[0]};
        digest_item.half_index  = half_reg;
        digest_item.last_half   = half_reg;
    end

    // Round function
    always_comb
    begin
        unique case (round_reg[5:4])
            2'd0: f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: f = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2: f = b_reg ^ c_reg ^ d_reg;
            2'd3: f = c_reg ^ (b_reg | ~d_reg);
        endcase
        sum     = a_reg + f + ROUND_K[round_reg] + ram_rdata;
        b_round = b_reg + rotl32(sum, ROT_AMT[{round_reg[5:4], round_reg[1:0]}]);
        folded[0] = cv_reg[0] + a_reg;
        folded[1] = cv_reg[1] + b_reg;
        folded[2] = cv_reg[2] + c_reg;
        folded[3] = cv_reg[3] + d_reg;
    end

    // Datapath
    always_comb
    begin
        round_next     = round_reg;
        bank_next      = bank_reg;
        last_next      = last_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        cv_next        = cv_reg;
        digest_next    = digest_reg;
        out_valid_next = out_valid_reg;
        half_next      = half_reg;

        if (out_valid_reg && pop)
        begin
            if (half_reg)
            begin
                out_valid_next = 1'b0;
                half_next      = 1'b0;
            end
            else
            begin
                half_next = 1'b1;
            end
        end

        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_pop)
                begin
                    round_next = 6'd0;
                    bank_next  = q_desc.bank;
                    last_next  = q_desc.last;
                    a_next     = cv_reg[0];
                    b_next     = cv_reg[1];
                    c_next     = cv_reg[2];
                    d_next     = cv_reg[3];
                end
            end
            BK_ROUND:
            begin
                a_next     = d_reg;
                b_next     = b_round;
                c_next     = b_reg;
                d_next     = c_reg;
                round_next = round_reg + 6'd1;
            end
            BK_FOLD:
            begin
                if (last_reg)
                begin
                    digest_next    = folded;
                    cv_next        = MD5_IV;
                    out_valid_next = 1'b1;
                    half_next      = 1'b0;
                end
                else
                begin
                    cv_next = folded;
                end
            end
            default:
            begin
                round_next = round_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            round_reg     <= 6'd0;
            cv_reg        <= MD5_IV;
            out_valid_reg <= 1'b0;
            half_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            cv_reg        <= cv_next;
            out_valid_reg <= out_valid_next;
            half_reg      <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bank_reg   <= bank_next;
        last_reg   <= last_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        d_reg      <= d_next;
        digest_reg <= digest_next;
    end

endmodule

@@ rtl/md5_stream_hasher.sv @@
// ---------------------------------------------------------------------------
// md5_stream_hasher
// Byte-in MD5: 1 byte per cycle while a block bank is free; the single round
// engine works one 64-byte block at a time (one round per cycle) while the
// front end fills the other bank. After the final marker, padding and length
// enter one byte per cycle while a bank is free (input held full), and the
// first digest half appears once the engine has folded the last block.
// Reset clears control state and loads the MD5 initial words; no RAM clearing.
// ---------------------------------------------------------------------------
module md5_stream_hasher (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  md5sh_pkg::byte_item_t   byte_item,
    input  logic                    pop,
    output logic                    empty,
    output md5sh_pkg::digest_item_t digest_item
);
    import md5sh_pkg::*;

    logic              blk_done;
    logic              desc_push;
    desc_t             desc_in;
    desc_t             desc_out;
    logic              q_empty;
    logic              q_pop;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [RAM_AW-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    md5sh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .byte_item (byte_item),
        .blk_done  (blk_done),
        .desc_push (desc_push),
        .desc      (desc_in),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    md5sh_descq u_descq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (desc_push),
        .wr_desc (desc_in),
        .rd      (q_pop),
        .rd_desc (desc_out),
        .q_empty (q_empty)
    );

    md5sh_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RAM_DEPTH)
    ) u_blk_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    md5sh_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_desc      (desc_out),
        .q_pop       (q_pop),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .blk_done    (blk_done),
        .empty       (empty),
        .pop         (pop),
        .digest_item (digest_item)
    );

endmodule

@@ rtl/md5sh_checker.sv @@
// ---------------------------------------------------------------------------
// md5sh_checker
// Port-level checks on the hasher's digest output order and input hold-off.
// ---------------------------------------------------------------------------
`include "md5_stream_hasher_macros.svh"

module md5sh_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    push,
    input logic                    full,
    input md5sh_pkg::byte_item_t   byte_item,
    input logic                    pop,
    input logic                    empty,
    input md5sh_pkg::digest_item_t digest_item
);
    import md5sh_pkg::*;

    logic take_tx;
    logic hi_half;

    assign take_tx = pop && !empty;
    assign hi_half = digest_item.half_index;

    // the second half is always the last one
    `MD5SH_ASSERT_IMP(a_last_is_second, !empty, hi_half == digest_item.last_half)

    // taking the first half exposes the second half right after
    `MD5SH_ASSERT_NXT(a_second_follows, take_tx && !hi_half, !empty && hi_half)

    // a new digest never shows up directly after the last half is taken
    `MD5SH_ASSERT_NXT(a_drain_after_last, take_tx && digest_item.last_half, empty)

    // hold the input off while padding follows an end marker
    `MD5SH_ASSERT_NXT(a_final_holds_input, push && !full && byte_item.final_req, full)

endmodule

bind md5_stream_hasher md5sh_checker u_md5sh_checker (.*);

@@ verif/md5_stream_hasher_tb.sv @@
// ---------------------------------------------------------------------------
// md5_stream_hasher_tb
// Self-checking bench for the byte-stream MD5 hasher. A short directed run
// covers empty messages, bare and byte-carrying end markers and ignored
// steps. Random messages follow, most short, some at padding boundaries. A
// local MD5 model predicts both digest halves of every message. Each popped
// transaction is checked against the oldest prediction, under random push
// and pop throttling.
// ---------------------------------------------------------------------------
module md5_stream_hasher_tb;

    import md5sh_pkg::byte_item_t;
    import md5sh_pkg::digest_item_t;

    localparam int RANDOM_ITEMS = 650;
    localparam int MIN_MESSAGES = 30;
    localparam int DRAIN_CYCLES = 150;

    localparam logic [127:0] DIGEST_EMPTY = 128'h7e42f8ec980980e9_04b2008fd98c1dd4;
    localparam logic [127:0] DIGEST_A     = 128'h61267769e299c331_a8b6f1c0b975c10c;

    localparam logic [0:63][31:0] MD5_ADD = {
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [0:15][4:0] MD5_SHIFT = {
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    typedef struct packed {
        logic [7:0]   data_byte;
        logic         byte_present;
        logic         final_req;
        logic         known;
        logic [127:0] digest;
    } stim_row_t;

    localparam int NUM_DIRECTED = 13;

    // Known digests are typed in only for the empty message and "a".
    localparam stim_row_t [0:NUM_DIRECTED-1] DIRECTED_ROWS = {
        {8'h00, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},
        {8'h61, 1'b1, 1'b1, 1'b1, DIGEST_A},
        {8'hff, 1'b0, 1'b0, 1'b0, 128'h0},
        {8'h00, 1'b1, 1'b0, 1'b0, 128'h0},
        {8'hff, 1'b1, 1'b0, 1'b0, 128'h0},
        {8'h80, 1'b1, 1'b0, 1'b0, 128'h0},
        {8'h01, 1'b1, 1'b0, 1'b0, 128'h0},
        {8'h7f, 1'b1, 1'b0, 1'b0, 128'h0},
        {8'ha5, 1'b0, 1'b0, 1'b0, 128'h0},
        {8'h5a, 1'b0, 1'b1, 1'b0, 128'h0},
        {8'hff, 1'b1, 1'b1, 1'b0, 128'h0},
        {8'hff, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},
        {8'h00, 1'b1, 1'b1, 1'b0, 128'h0}
    };

    logic         clk;
    logic         rst_n;
    logic         push;
    logic         full;
    byte_item_t   byte_item;
    logic         pop;
    logic         empty;
    digest_item_t digest_item;

    // Model state
    logic [31:0]  chain_words [4];
    logic [7:0]   block_bytes [64];
    logic [63:0]  message_bytes;
    logic [5:0]   fill_pos;

    digest_item_t pending_halves [$];
    logic         known_valid;
    logic [127:0] known_digest;
    int           items_sent;
    int           messages_sent;
    int           error_count;
    int           tx_idle_pct;
    int           rx_idle_pct;

    md5_stream_hasher uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .byte_item   (byte_item),
        .pop         (pop),
        .empty       (empty),
        .digest_item (digest_item)
    );

    always #5 clk = ~clk;

    function automatic void md5_restart();
        chain_words[0] = 32'h67452301;
        chain_words[1] = 32'hefcdab89;
        chain_words[2] = 32'h98badcfe;
        chain_words[3] = 32'h10325476;
        message_bytes  = 64'd0;
        fill_pos       = 6'd0;
    endfunction

    function automatic void md5_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, f, sum, held;
        int          i, g, ph, sh;
        for (i = 0; i < 16; i++)
        begin
            w[i] = {block_bytes[4*i+3], block_bytes[4*i+2],
                    block_bytes[4*i+1], block_bytes[4*i]};
        end
        a = chain_words[0];
        b = chain_words[1];
        c = chain_words[2];
        d = chain_words[3];
        for (i = 0; i < 64; i++)
        begin
            ph = i / 16;
            case (ph)
                0:
                begin
                    f = (b & c) | (~b & d);
                    g = i;
                end
                1:
                begin
                    f = (b & d) | (c & ~d);
                    g = (5 * i + 1) % 16;
                end
                2:
                begin
                    f = b ^ c ^ d;
                    g = (3 * i + 5) % 16;
                end
                default:
                begin
                    f = c ^ (b | ~d);
                    g = (7 * i) % 16;
                end
            endcase
            sh   = MD5_SHIFT[ph * 4 + i % 4];
            sum  = a + f + MD5_ADD[i] + w[g];
            held = d;
            d    = c;
            c    = b;
            b    = b + ((sum << sh) | (sum >> (32 - sh)));
            a    = held;
        end
        chain_words[0] = chain_words[0] + a;
        chain_words[1] = chain_words[1] + b;
        chain_words[2] = chain_words[2] + c;
        chain_words[3] = chain_words[3] + d;
    endfunction

    function automatic void md5_absorb(input logic [7:0] v);
        block_bytes[fill_pos] = v;
        fill_pos = fill_pos + 6'd1;
        if (fill_pos == 6'd0)
        begin
            md5_compress();
        end
    endfunction

    // Returns 1 when the item closes a message; digest holds {half 1, half 0}.
    function automatic bit md5_feed(input byte_item_t it, output logic [127:0] digest);
        logic [63:0] bit_len;
        int          k;
        digest = '0;
        if (it.byte_present)
        begin
            md5_absorb(it.data_byte);
            message_bytes = message_bytes + 64'd1;
        end
        if (!it.final_req)
        begin
            return 1'b0;
        end
        bit_len = message_bytes << 3;
        md5_absorb(8'h80);
        while (fill_pos != 6'd56)
        begin
            md5_absorb(8'h00);
        end
        for (k = 0; k < 8; k++)
        begin
            md5_absorb(bit_len[8*k +: 8]);
        end
        digest = {chain_words[3], chain_words[2], chain_words[1], chain_words[0]};
        md5_restart();
        return 1'b1;
    endfunction

    function automatic void update_idling();
        if (items_sent < RANDOM_ITEMS / 3)
        begin
            tx_idle_pct = 26;
            rx_idle_pct = 59;
        end
        else if (items_sent < 2 * RANDOM_ITEMS / 3)
        begin
            tx_idle_pct = 59;
            rx_idle_pct = 26;
        end
        else
        begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte_item(input logic [7:0] data, input logic present,
                                  input logic fin, input logic known,
                                  input logic [127:0] digest);
        update_idling();
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push         <= 1'b1;
        byte_item    <= '{data_byte: data, byte_present: present, final_req: fin};
        known_valid  = known;
        known_digest = digest;
        do
        begin
            @(posedge clk);
        end
        while (full);
        @(negedge clk);
        if (present || fin)
        begin
            items_sent++;
        end
    endtask

    // Lengths are mostly short; some sit at the one-block / two-block padding boundaries.
    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 12)
        begin
            case ($urandom_range(7))
                0: return 55;
                1: return 56;
                2: return 57;
                3: return 63;
                4: return 64;
                5: return 65;
                6: return 0;
                default: return 1;
            endcase
        end
        else if (r < 16)
        begin
            return $urandom_range(130, 66);
        end
        return $urandom_range(24);
    endfunction

    task automatic send_message(input int len);
        int i;
        bit fin_on_byte;
        fin_on_byte = (len > 0) && ($urandom_range(1) == 1);
        for (i = 0; i < len; i++)
        begin
            // Sprinkle empty steps between message bytes.
            if ($urandom_range(9) == 0)
            begin
                send_byte_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, '0);
            end
            send_byte_item(8'($urandom_range(255)), 1'b1,
                           fin_on_byte && (i == len - 1), 1'b0, '0);
        end
        if (!fin_on_byte)
        begin
            send_byte_item(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, '0);
        end
        messages_sent++;
    endtask

    always @(negedge clk)
    begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        logic [127:0] digest;
        digest_item_t want;
        bit           done;
        if (rst_n && push && !full)
        begin
            done = md5_feed(byte_item, digest);
            if (done)
            begin
                if (known_valid)
                begin
                    digest = known_digest;
                end
                pending_halves.push_back('{digest_half: digest[63:0],
                                           half_index: 1'b0, last_half: 1'b0});
                pending_halves.push_back('{digest_half: digest[127:64],
                                           half_index: 1'b1, last_half: 1'b1});
            end
        end
        if (rst_n && pop && !empty)
        begin
            if (pending_halves.size() == 0)
            begin
                $display("%0t: unexpected transaction: digest_half=%h half_index=%b last_half=%b",
                         $time, digest_item.digest_half, digest_item.half_index,
                         digest_item.last_half);
                error_count++;
            end
            else
            begin
                want = pending_halves.pop_front();
                if (digest_item.digest_half !== want.digest_half
                    || digest_item.half_index !== want.half_index
                    || digest_item.last_half !== want.last_half)
                begin
                    $display("%0t: mismatch: expected %h/%b/%b, actual %h/%b/%b",
                             $time, want.digest_half, want.half_index, want.last_half,
                             digest_item.digest_half, digest_item.half_index,
                             digest_item.last_half);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        int i;
        clk           = 1'b0;
        rst_n         = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        byte_item     = '0;
        known_valid   = 1'b0;
        known_digest  = '0;
        items_sent    = 0;
        messages_sent = 0;
        error_count   = 0;
        tx_idle_pct   = 26;
        rx_idle_pct   = 59;
        md5_restart();
        for (i = 0; i < 64; i++)
        begin
            block_bytes[i] = 8'h00;
        end
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < NUM_DIRECTED; i++)
        begin
            send_byte_item(DIRECTED_ROWS[i].data_byte, DIRECTED_ROWS[i].byte_present,
                           DIRECTED_ROWS[i].final_req, DIRECTED_ROWS[i].known,
                           DIRECTED_ROWS[i].digest);
        end

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS || messages_sent < MIN_MESSAGES)
        begin
            send_message(pick_length());
        end
        push <= 1'b0;

        while (pending_halves.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("md5_stream_hasher_tb: done, clean");
        end
        else
        begin
            $display("md5_stream_hasher_tb: done, errors");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("md5_stream_hasher_tb: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/md5sh_pkg.sv
rtl/md5sh_ram.sv
rtl/md5sh_front.sv
rtl/md5sh_descq.sv
rtl/md5sh_back.sv
rtl/md5_stream_hasher.sv
rtl/md5sh_checker.sv
verif/md5_stream_hasher_tb.sv
